// File: rtl/core/pkc_pkg.sv
// Shared types and constants for the path k-mer canonicalizer.
`timescale 1ns / 1ps
`default_nettype none

package pkc_pkg;

   localparam int MAX_K_DEF    = 16;
   localparam int ID_WIDTH_DEF = 32;
   localparam int KSIZE_WIDTH  = 5;
   localparam int ABUND_WIDTH  = 31;
   localparam int INDEX_WIDTH  = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP_RD,
      ST_CMP_EV,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_HOLD
   } pkc_state_type;

endpackage

`default_nettype wire

// File: rtl/core/pkc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_a_addr,
   output logic      [WIDTH-1:0] rd_a_data,
   input  wire logic [AW-1:0]    rd_b_addr,
   output logic      [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/path_kmer_canonicalizer.sv
// Canonical k-mer extractor over paths of signed unit ids.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted id is written into a circular window RAM; once the current path
// holds at least k ids (k = the csr k-mer length, 0 read as 1, capped at MAX_K), the
// last k ids are emitted as k items, in canonical order: forward, or reversed
// with every id negated, whichever is smaller by signed lexicographic compare
// (forward on a tie). An item that completes no k-mer leaves req_tready high;
// else c compare steps follow, where c (1..k) is the number of compare steps
// up to the first differing element, then k output elements held until
// rsp_tready. Each step and element waits one registered read of the window
// RAM. req_tready is low until the last element has been taken.
module path_kmer_canonicalizer #(
   parameter int MAX_K    = pkc_pkg::MAX_K_DEF,
   parameter int ID_WIDTH = pkc_pkg::ID_WIDTH_DEF,
   localparam int REQ_W =
      ((ID_WIDTH + pkc_pkg::ABUND_WIDTH + 7) / 8) * 8,
   localparam int RSP_W =
      ((ID_WIDTH + pkc_pkg::INDEX_WIDTH + pkc_pkg::ABUND_WIDTH + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // tdata: unit_id, abundance
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [REQ_W-1:0]                req_tdata,
   // tuser: path_start
   input  wire logic                            req_tuser,
   // tdata: kmer_element, element_index, kmer_abundance
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [RSP_W-1:0]                rsp_tdata,
   // tuser: reversed
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire logic                            csr_wr_en,
   input  wire logic [pkc_pkg::KSIZE_WIDTH-1:0] csr_wr_data
);

   localparam int AW      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int DEPTH   = 1 << AW;
   localparam int KW      = $clog2(MAX_K + 1);
   localparam int ABUND_W = pkc_pkg::ABUND_WIDTH;
   localparam int IDX_W   = pkc_pkg::INDEX_WIDTH;

   pkc_pkg::pkc_state_type state_ff, state_in;

   logic [pkc_pkg::KSIZE_WIDTH-1:0] ksize_ff, ksize_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [KW-1:0]      fill_ff, fill_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      idx_ff, idx_in;
   logic [ABUND_W-1:0] abund_ff, abund_in;
   logic               use_rev_ff, use_rev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [KW-1:0]             k_eff;
   logic [KW-1:0]             fill_next;
   logic                      req_fire;
   logic [AW-1:0]             fwd_addr;
   logic [AW-1:0]             rev_addr;
   logic signed [ID_WIDTH-1:0] fwd_id;
   logic signed [ID_WIDTH-1:0] raw_id;
   logic signed [ID_WIDTH-1:0] rev_id;
   logic signed [ID_WIDTH-1:0] elem_id;
   logic                      idx_last;

   assign req_tready = (state_ff == pkc_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // k as used: zero reads as one, large values clip to MAX_K
   always_comb begin
      if (ksize_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(ksize_ff) > 32'(MAX_K)) begin
         k_eff = KW'(MAX_K);
      end else begin
         k_eff = KW'(ksize_ff);
      end
   end

   always_comb begin
      if (req_tuser) begin
         fill_next = KW'(1);
      end else if (32'(fill_ff) >= 32'(MAX_K)) begin
         fill_next = fill_ff;
      end else begin
         fill_next = fill_ff + KW'(1);
      end
   end

   // newest id sits at wp_ff - 1; forward walks up from wp_ff - k, reverse walks down
   assign fwd_addr = wp_ff - AW'(k_ff) + AW'(idx_ff);
   assign rev_addr = wp_ff - AW'(1) - AW'(idx_ff);
   assign rev_id   = -raw_id;
   assign elem_id  = use_rev_ff ? rev_id : fwd_id;
   assign idx_last = (idx_ff == k_ff - KW'(1));

   pkc_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (DEPTH)
   ) u_window (
      .clock     (clock),
      .wr_en     (req_fire),
      .wr_addr   (wp_ff),
      .wr_data   (req_tdata[ID_WIDTH-1:0]),
      .rd_a_addr (fwd_addr),
      .rd_a_data (fwd_id),
      .rd_b_addr (rev_addr),
      .rd_b_data (raw_id)
   );

   always_comb begin
      state_in     = state_ff;
      ksize_in     = csr_wr_en ? csr_wr_data : ksize_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      abund_in     = abund_ff;
      use_rev_in   = use_rev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         pkc_pkg::ST_IDLE: begin
            if (req_fire) begin
               wp_in    = wp_ff + AW'(1);
               fill_in  = fill_next;
               k_in     = k_eff;
               abund_in = req_tdata[ID_WIDTH +: ABUND_W];
               idx_in   = '0;
               if (fill_next >= k_eff) begin
                  state_in = pkc_pkg::ST_CMP_RD;
               end
            end
         end
         pkc_pkg::ST_CMP_RD: begin
            state_in = pkc_pkg::ST_CMP_EV;
         end
         pkc_pkg::ST_CMP_EV: begin
            // first differing element decides; a full tie keeps forward
            if (fwd_id != rev_id) begin
               use_rev_in = (rev_id < fwd_id);
               idx_in     = '0;
               state_in   = pkc_pkg::ST_OUT_RD;
            end else if (idx_last) begin
               use_rev_in = 1'b0;
               idx_in     = '0;
               state_in   = pkc_pkg::ST_OUT_RD;
            end else begin
               idx_in   = idx_ff + KW'(1);
               state_in = pkc_pkg::ST_CMP_RD;
            end
         end
         pkc_pkg::ST_OUT_RD: begin
            state_in = pkc_pkg::ST_OUT_LD;
         end
         pkc_pkg::ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = RSP_W'({abund_ff, IDX_W'(idx_ff), elem_id});
            rsp_last_in  = idx_last;
            state_in     = pkc_pkg::ST_OUT_HOLD;
         end
         pkc_pkg::ST_OUT_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (idx_last) begin
                  state_in = pkc_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + KW'(1);
                  state_in = pkc_pkg::ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in     = pkc_pkg::ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pkc_pkg::ST_IDLE;
         ksize_ff     <= pkc_pkg::KSIZE_WIDTH'(1);
         wp_ff        <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         use_rev_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ksize_ff     <= ksize_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         use_rev_ff   <= use_rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      abund_ff    <= abund_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = use_rev_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_valid_only_in_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == pkc_pkg::ST_OUT_HOLD))
      else $error("rsp_tvalid outside output hold state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (fill_next >= k_eff)) |=> !req_tready)
      else $error("ready stayed high after an item that completes a k-mer");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tdata[ID_WIDTH +: IDX_W] == IDX_W'(k_ff - KW'(1))))
      else $error("last element index does not match k");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_K))
      else $error("fill count beyond window depth");
`endif

endmodule

`default_nettype wire
